// ===== hdl/pwag_pkg.sv =====
// Shared types and constants for the perspective warp address generator.
package pwag_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int DIM_W       = 13;
  localparam int SUM_W       = 50;
  localparam int FRAC_W      = 16;
  localparam int INT_W       = 17;
  localparam int QUO_W       = INT_W + FRAC_W;
  localparam int DIV_LAT     = QUO_W + 2;

  localparam logic [CFG_IDX_W-1:0] CfgXGains    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CfgYGains    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CfgWGains    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CfgXyOffsets = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CfgWOffset   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CfgSrcCols   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CfgSrcRows   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CfgDstCols   = 3'd7;

  typedef struct packed {
    logic [11:0] dst_x;
    logic [11:0] dst_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic [23:0]        src_index;
    logic [23:0]        dst_index;
    logic               in_bounds;
  } out_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic sat;
  } div_flags_t;

endpackage

// ===== hdl/pwag_div.sv =====
// Pipelined restoring divider: round-half-even of num*2^16/den, saturated to 16 bits.
module pwag_div #(
  parameter int NW = pwag_pkg::SUM_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [NW-1:0]      in_num,
  input  logic [NW-1:0]      in_den,
  input  logic               in_neg,
  input  logic               in_zero,
  output logic               out_valid,
  output logic signed [15:0] out_coord
);
  import pwag_pkg::*;

  localparam int RW = NW + FRAC_W;

  logic [RW-1:0]    rem_r [0:QUO_W];
  logic [QUO_W-1:0] quo_r [0:QUO_W];
  logic [NW-1:0]    den_r [0:QUO_W];
  div_flags_t       flg_r [0:QUO_W];
  logic             vld_r [0:QUO_W];

  logic               sat_nxt;
  logic [NW:0]        rem2;
  logic               rnd_up;
  logic [QUO_W:0]     q_rnd;
  logic signed [15:0] coord_nxt;
  logic signed [15:0] coord_r;
  logic               vout_r;

  assign sat_nxt = {{INT_W{1'b0}}, in_num} >= {in_den, {INT_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    rem_r[0] <= {in_num, {FRAC_W{1'b0}}};
    quo_r[0] <= '0;
    den_r[0] <= in_den;
    flg_r[0] <= '{neg: in_neg, zero: in_zero, sat: sat_nxt};
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int Sh = QUO_W - 1 - k;
    logic [RW-1:0] hi;
    logic [RW-1:0] dsh;
    logic          ge;
    assign hi  = rem_r[k] >> Sh;
    assign ge  = hi >= RW'(den_r[k]);
    assign dsh = RW'(den_r[k]) << Sh;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      rem_r[k+1] <= ge ? rem_r[k] - dsh : rem_r[k];
      quo_r[k+1] <= {quo_r[k][QUO_W-2:0], ge};
      den_r[k+1] <= den_r[k];
      flg_r[k+1] <= flg_r[k];
    end
  end

  assign rem2   = {rem_r[QUO_W][NW-1:0], 1'b0};
  assign rnd_up = (rem2 > {1'b0, den_r[QUO_W]})
               || ((rem2 == {1'b0, den_r[QUO_W]}) && quo_r[QUO_W][0]);
  assign q_rnd  = {1'b0, quo_r[QUO_W]} + (QUO_W+1)'(rnd_up);

  always_comb begin
    if (flg_r[QUO_W].zero) begin
      coord_nxt = '0;
    end else if (flg_r[QUO_W].neg) begin
      if (flg_r[QUO_W].sat || q_rnd > (QUO_W+1)'(32768)) begin
        coord_nxt = 16'sh8000;
      end else begin
        coord_nxt = -$signed(q_rnd[15:0]);
      end
    end else begin
      if (flg_r[QUO_W].sat || q_rnd > (QUO_W+1)'(32767)) begin
        coord_nxt = 16'sh7fff;
      end else begin
        coord_nxt = $signed(q_rnd[15:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else begin
      vout_r <= vld_r[QUO_W];
    end
    coord_r <= coord_nxt;
  end

  assign out_valid = vout_r;
  assign out_coord = coord_r;

endmodule

// ===== hdl/perspective_warp_address_gen.sv =====
// Top level: homography address generator, nearest-neighbor, fully pipelined.
//
//  channel | ports                      | flow
//  --------+----------------------------+---------------------------------
//  input   | start, busy, in_data       | beat taken when start & !busy
//  result  | out_strobe, out_data       | one-cycle strobe, always taken
//  config  | cfg_we, cfg_index, cfg_data| write when cfg_we
//
// One beat per clock; latency is set by the bit-per-stage quotient pipeline
// of the two dividers.
// Synchronous active-low reset clears valid bits and loads config registers with their defaults.
// busy stays low: results are never held off, so nothing stalls.
module perspective_warp_address_gen #(
  parameter int MAX_DIM = pwag_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  pwag_pkg::in_t                       in_data,
  output logic                                out_strobe,
  output pwag_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [pwag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwag_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pwag_pkg::*;

  localparam logic [16:0] MaxDimC = 17'(MAX_DIM);

  logic [63:0]      x_gains_r, y_gains_r, w_gains_r, xy_offsets_r;
  logic [31:0]      w_offset_r;
  logic [DIM_W-1:0] src_cols_r, src_rows_r, dst_cols_r;
  logic [DIM_W-1:0] sc, sr, dc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_gains_r    <= '0;
      y_gains_r    <= '0;
      w_gains_r    <= '0;
      xy_offsets_r <= '0;
      w_offset_r   <= 32'h0100_0000;
      src_cols_r   <= 13'd4096;
      src_rows_r   <= 13'd4096;
      dst_cols_r   <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgXGains:    x_gains_r    <= cfg_data;
        CfgYGains:    y_gains_r    <= cfg_data;
        CfgWGains:    w_gains_r    <= cfg_data;
        CfgXyOffsets: xy_offsets_r <= cfg_data;
        CfgWOffset:   w_offset_r   <= cfg_data[31:0];
        CfgSrcCols:   src_cols_r   <= cfg_data[DIM_W-1:0];
        CfgSrcRows:   src_rows_r   <= cfg_data[DIM_W-1:0];
        CfgDstCols:   dst_cols_r   <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign sc = ({4'b0, src_cols_r} > MaxDimC) ? MaxDimC[DIM_W-1:0] : src_cols_r;
  assign sr = ({4'b0, src_rows_r} > MaxDimC) ? MaxDimC[DIM_W-1:0] : src_rows_r;
  assign dc = ({4'b0, dst_cols_r} > MaxDimC) ? MaxDimC[DIM_W-1:0] : dst_cols_r;

  assign busy = 1'b0;

  // stage 1: products
  logic signed [12:0] xs, ys;
  logic               v1_r;
  logic signed [44:0] pa_r, pb_r, pd_r, pe_r, pg_r, ph_r;
  logic [23:0]        dprod_r;
  logic [11:0]        dx1_r;

  assign xs = $signed({1'b0, in_data.dst_x});
  assign ys = $signed({1'b0, in_data.dst_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    pa_r    <= $signed(x_gains_r[31:0]) * xs;
    pb_r    <= $signed(x_gains_r[63:32]) * ys;
    pd_r    <= $signed(y_gains_r[31:0]) * xs;
    pe_r    <= $signed(y_gains_r[63:32]) * ys;
    pg_r    <= $signed(w_gains_r[31:0]) * xs;
    ph_r    <= $signed(w_gains_r[63:32]) * ys;
    dprod_r <= 24'(in_data.dst_y * dc);
    dx1_r   <= in_data.dst_x;
  end

  // stage 2: sums
  logic             v2_r;
  logic [SUM_W-1:0] xn_r, yn_r, wn_r;
  logic [23:0]      didx2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    xn_r <= {{5{pa_r[44]}}, pa_r} + {{5{pb_r[44]}}, pb_r}
          + {{10{xy_offsets_r[31]}}, xy_offsets_r[31:0], 8'b0};
    yn_r <= {{5{pd_r[44]}}, pd_r} + {{5{pe_r[44]}}, pe_r}
          + {{10{xy_offsets_r[63]}}, xy_offsets_r[63:32], 8'b0};
    wn_r <= {{5{pg_r[44]}}, pg_r} + {{5{ph_r[44]}}, ph_r}
          + {{2{w_offset_r[31]}}, w_offset_r, 16'b0};
    didx2_r <= dprod_r + 24'(dx1_r);
  end

  // stage 3: magnitudes and signs
  logic             v3_r;
  logic [SUM_W-1:0] ux_r, uy_r, uw_r;
  logic             negx_r, negy_r, zero_r;
  logic [23:0]      didx3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    ux_r    <= xn_r[SUM_W-1] ? -xn_r : xn_r;
    uy_r    <= yn_r[SUM_W-1] ? -yn_r : yn_r;
    uw_r    <= wn_r[SUM_W-1] ? -wn_r : wn_r;
    negx_r  <= xn_r[SUM_W-1] ^ wn_r[SUM_W-1];
    negy_r  <= yn_r[SUM_W-1] ^ wn_r[SUM_W-1];
    zero_r  <= wn_r == '0;
    didx3_r <= didx2_r;
  end

  // dividers
  logic               vdx, vdy;
  logic signed [15:0] sx, sy;

  pwag_div #(.NW(SUM_W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .in_valid(v3_r), .in_num(ux_r), .in_den(uw_r),
    .in_neg(negx_r), .in_zero(zero_r), .out_valid(vdx), .out_coord(sx)
  );

  pwag_div #(.NW(SUM_W)) u_div_y (
    .clk(clk), .rst_n(rst_n), .in_valid(v3_r), .in_num(uy_r), .in_den(uw_r),
    .in_neg(negy_r), .in_zero(zero_r), .out_valid(vdy), .out_coord(sy)
  );

  logic [23:0] dly_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    dly_r[0] <= didx3_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  // stage 4: bounds and source row product
  logic               v4_r, inb4_r;
  logic signed [15:0] sx4_r, sy4_r;
  logic [23:0]        sprod_r, didx4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= vdx && vdy;
    end
    inb4_r  <= !sx[15] && !sy[15] && (sx < $signed({3'b0, sc}))
            && (sy < $signed({3'b0, sr}));
    sprod_r <= 24'(sy[14:0] * sc);
    sx4_r   <= sx;
    sy4_r   <= sy;
    didx4_r <= dly_r[DIV_LAT-1];
  end

  // stage 5: result register
  logic v5_r;
  out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    out_r.src_x     <= sx4_r;
    out_r.src_y     <= sy4_r;
    out_r.src_index <= inb4_r ? sprod_r + 24'(sx4_r[14:0]) : '0;
    out_r.dst_index <= didx4_r;
    out_r.in_bounds <= inb4_r;
  end

  assign out_strobe = v5_r;
  assign out_data   = out_r;

`ifndef NO_ASSERTIONS
  a_inb_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.in_bounds |-> !out_data.src_x[15] && !out_data.src_y[15])
    else $error("in-bounds result with negative source coordinate");

  a_oob_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.in_bounds |-> out_data.src_index == '0)
    else $error("out-of-bounds result with nonzero source index");

  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    vdx == vdy)
    else $error("divider lanes out of step");
`endif

endmodule
